// ===== src/cascaded_position_speed_pid_top_defines.svh =====
// assertion macros for the cascaded pid block
`ifndef CASCADED_POSITION_SPEED_PID_TOP_DEFINES_SVH
`define CASCADED_POSITION_SPEED_PID_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, quiet during reset
`define CPSP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CPSP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/cpsp_pkg.sv =====
package cpsp_pkg;

    // fixed field widths
    localparam int GAIN_W   = 24;
    localparam int SPD_W    = 16;
    localparam int DRIVE_W  = 14;
    localparam int OUTMAX_W = 15;
    localparam int APB_AW   = 5;
    localparam int APB_DW   = 32;

    // defaults for the top level parameters
    localparam int POS_WIDTH_DEF = 24;
    localparam int ACC_WIDTH_DEF = 40;
    localparam int GAIN_FRAC_DEF = 8;

    // shared multiplier and term accumulator
    localparam int CHUNK_W      = 24;
    localparam int TOT_W        = 64;
    localparam int TERM_LIM_LOG = 61;

    localparam int DRIVE_CAP = 5000;

    // register reset values, gains in q16.8
    localparam logic [GAIN_W-1:0]   POS_KP_RST  = 24'd15360;
    localparam logic [GAIN_W-1:0]   POS_KI_RST  = 24'd0;
    localparam logic [GAIN_W-1:0]   POS_KD_RST  = 24'd204800;
    localparam logic [GAIN_W-1:0]   SPD_KP_RST  = 24'd640;
    localparam logic [GAIN_W-1:0]   SPD_KI_RST  = 24'd0;
    localparam logic [GAIN_W-1:0]   SPD_KD_RST  = 24'd0;
    localparam logic [OUTMAX_W-1:0] OUT_MAX_RST = 15'd5000;

    typedef enum logic [2:0] {
        REG_POS_KP  = 3'd0,
        REG_POS_KI  = 3'd1,
        REG_POS_KD  = 3'd2,
        REG_SPD_KP  = 3'd3,
        REG_SPD_KI  = 3'd4,
        REG_SPD_KD  = 3'd5,
        REG_OUT_MAX = 3'd6
    } reg_idx_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ERR,
        S_UPD,
        S_MUL,
        S_ACC,
        S_SCALE,
        S_DONE
    } state_t;

    // order in which the three terms of one loop go through the multiplier
    typedef enum logic [1:0] {
        TERM_P = 2'd0,
        TERM_D = 2'd1,
        TERM_I = 2'd2
    } term_t;

    typedef struct packed {
        logic load;
        logic clr_total;
        logic mul_en;
        logic mul_first;
        logic acc_en;
    } mac_ctrl_t;

endpackage

// ===== src/cpsp_mac.sv =====
module cpsp_mac #(
    parameter int OP_W   = 48,
    parameter int NCHUNK = 2,
    parameter int CIW    = 1
) (
    input  logic                                 clk,
    input  cpsp_pkg::mac_ctrl_t                  ctrl,
    input  logic [CIW-1:0]                       chunk_sel,
    input  logic signed [OP_W-1:0]               operand,
    input  logic [cpsp_pkg::GAIN_W-1:0]          gain,
    output logic signed [cpsp_pkg::TOT_W-1:0]    total
);
    import cpsp_pkg::*;

    localparam int MAG_PW = NCHUNK * CHUNK_W;
    localparam int PP_W   = CHUNK_W + GAIN_W;
    localparam int PROD_W = MAG_PW + GAIN_W;
    localparam logic [PROD_W-1:0] TERM_LIM_P = PROD_W'(1) << TERM_LIM_LOG;

    logic [MAG_PW-1:0]        mag_reg;
    logic                     sign_reg;
    logic [PROD_W-1:0]        prod_reg;
    logic signed [TOT_W-1:0]  total_reg;

    logic [OP_W-1:0]          op_abs;
    logic [CHUNK_W-1:0]       chunk;
    logic [PP_W-1:0]          pp;
    logic [PROD_W-1:0]        pp_sh;
    logic [PROD_W-1:0]        prod_next;
    logic [PROD_W-1:0]        prod_clamp;
    logic signed [TOT_W-1:0]  term_mag;
    logic signed [TOT_W-1:0]  term_val;

    always_comb
    begin
        op_abs     = operand[OP_W-1] ? $unsigned(-operand) : $unsigned(operand);
        chunk      = mag_reg[chunk_sel*CHUNK_W +: CHUNK_W];
        pp         = chunk * gain;
        pp_sh      = PROD_W'(pp) << (chunk_sel * CHUNK_W);
        prod_next  = (ctrl.mul_first ? '0 : prod_reg) + pp_sh;
        // each product is held to the term limit before the sum
        prod_clamp = (prod_reg > TERM_LIM_P) ? TERM_LIM_P : prod_reg;
        term_mag   = $signed(TOT_W'(prod_clamp));
        term_val   = sign_reg ? -term_mag : term_mag;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            mag_reg  <= MAG_PW'(op_abs);
            sign_reg <= operand[OP_W-1];
        end
        if (ctrl.mul_en)
        begin
            prod_reg <= prod_next;
        end
        if (ctrl.clr_total)
        begin
            total_reg <= '0;
        end
        else if (ctrl.acc_en)
        begin
            total_reg <= total_reg + term_val;
        end
    end

    assign total = total_reg;

endmodule

// ===== src/cascaded_position_speed_pid_top.sv =====
// channel  | handshake                  | payload
// ---------+----------------------------+-------------------------------------------
// config   | psel penable pwrite pready | paddr pwdata prdata
// input    | in_valid in_ready          | func position_target position_feedback
//          |                            | speed_feedback
// output   | out_valid out_ready        | drive speed_setpoint
//
// a control item runs the position loop and then the speed loop; each loop takes its
// error and sum, puts its 3 gain terms through the one 24x24 multiplier and scales
// a clear item skips both loops
// after reset all loop state is zero and gains hold their defaults; no clearing pass
// in_ready is low while an item is in work; a result waiting on out_ready holds
// the block in its final state until the output register is free
module cascaded_position_speed_pid_top #(
    parameter int POS_WIDTH = cpsp_pkg::POS_WIDTH_DEF,
    parameter int ACC_WIDTH = cpsp_pkg::ACC_WIDTH_DEF,
    parameter int GAIN_FRAC = cpsp_pkg::GAIN_FRAC_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [cpsp_pkg::APB_AW-1:0]         paddr,
    input  logic [cpsp_pkg::APB_DW-1:0]         pwdata,
    output logic [cpsp_pkg::APB_DW-1:0]         prdata,
    output logic                                pready,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                func,
    input  logic signed [POS_WIDTH-1:0]         position_target,
    input  logic signed [POS_WIDTH-1:0]         position_feedback,
    input  logic signed [cpsp_pkg::SPD_W-1:0]   speed_feedback,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [cpsp_pkg::DRIVE_W-1:0] drive,
    output logic signed [POS_WIDTH-1:0]         speed_setpoint
);
    import cpsp_pkg::*;
    `include "cascaded_position_speed_pid_top_defines.svh"

    localparam int E_W    = POS_WIDTH + 1;
    localparam int DE_W   = POS_WIDTH + 2;
    localparam int OP_W   = (ACC_WIDTH > DE_W) ? ACC_WIDTH : DE_W;
    localparam int NCHUNK = (OP_W + CHUNK_W - 1) / CHUNK_W;
    localparam int CIW    = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;

    localparam logic signed [TOT_W-1:0] SETP_MAX = (TOT_W'(1) <<< (POS_WIDTH - 1)) - 1;
    localparam logic signed [TOT_W-1:0] SETP_MIN = -SETP_MAX - 1;
    localparam logic signed [ACC_WIDTH-1:0] SUM_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
    localparam logic signed [ACC_WIDTH-1:0] SUM_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};
    localparam logic [OUTMAX_W-1:0] CAP = OUTMAX_W'(DRIVE_CAP);
    localparam logic signed [DRIVE_W:0] DRV_HI = (DRIVE_W+1)'(DRIVE_CAP);
    localparam logic signed [DRIVE_W:0] DRV_LO = -DRV_HI;

    // configuration registers
    logic [GAIN_W-1:0]   pos_kp_reg, pos_ki_reg, pos_kd_reg;
    logic [GAIN_W-1:0]   spd_kp_reg, spd_ki_reg, spd_kd_reg;
    logic [OUTMAX_W-1:0] out_max_reg;

    // loop state
    logic signed [E_W-1:0]       pos_err_reg, prev_pos_err_reg;
    logic signed [ACC_WIDTH-1:0] pos_sum_reg;
    logic signed [E_W-1:0]       spd_err_reg, prev_spd_err_reg;
    logic signed [ACC_WIDTH-1:0] spd_sum_reg;

    // sequencer and working registers
    state_t                      state_reg, state_next;
    logic                        loop_reg;
    term_t                       term_reg;
    logic [CIW-1:0]              chunk_reg;
    logic signed [DE_W-1:0]      de_reg;
    logic signed [POS_WIDTH-1:0] tgt_reg, fb_reg, setp_reg;
    logic signed [SPD_W-1:0]     sfb_reg;
    logic signed [DRIVE_W-1:0]   res_drive_reg;

    // output register
    logic                        out_valid_reg;
    logic signed [DRIVE_W-1:0]   drive_reg;
    logic signed [POS_WIDTH-1:0] setp_out_reg;

    mac_ctrl_t                   ctrl;
    logic                        cfg_wr;
    logic [2:0]                  cfg_idx;
    logic                        chunk_last;
    logic                        out_free;
    term_t                       ld_term;
    logic signed [OP_W-1:0]      operand;
    logic [GAIN_W-1:0]           gain;
    logic signed [TOT_W-1:0]     total;
    logic signed [TOT_W-1:0]     scaled;
    logic signed [E_W-1:0]       cur_e, cur_prev, e_new;
    logic signed [ACC_WIDTH-1:0] cur_sum, sum_sat;
    logic signed [ACC_WIDTH:0]   sum_wide;
    logic [OUTMAX_W-1:0]         lim;
    logic signed [TOT_W-1:0]     lim_s;
    logic signed [TOT_W-1:0]     drive_cl;
    logic signed [TOT_W-1:0]     setp_cl;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite;
    assign cfg_idx  = paddr[4:2];
    assign in_ready = (state_reg == S_IDLE);
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        prdata = '0;
        case (reg_idx_t'(cfg_idx))
            REG_POS_KP:  prdata = APB_DW'(pos_kp_reg);
            REG_POS_KI:  prdata = APB_DW'(pos_ki_reg);
            REG_POS_KD:  prdata = APB_DW'(pos_kd_reg);
            REG_SPD_KP:  prdata = APB_DW'(spd_kp_reg);
            REG_SPD_KI:  prdata = APB_DW'(spd_ki_reg);
            REG_SPD_KD:  prdata = APB_DW'(spd_kd_reg);
            REG_OUT_MAX: prdata = APB_DW'(out_max_reg);
            default:     prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_kp_reg  <= POS_KP_RST;
            pos_ki_reg  <= POS_KI_RST;
            pos_kd_reg  <= POS_KD_RST;
            spd_kp_reg  <= SPD_KP_RST;
            spd_ki_reg  <= SPD_KI_RST;
            spd_kd_reg  <= SPD_KD_RST;
            out_max_reg <= OUT_MAX_RST;
        end
        else if (cfg_wr)
        begin
            case (reg_idx_t'(cfg_idx))
                REG_POS_KP:  pos_kp_reg  <= pwdata[GAIN_W-1:0];
                REG_POS_KI:  pos_ki_reg  <= pwdata[GAIN_W-1:0];
                REG_POS_KD:  pos_kd_reg  <= pwdata[GAIN_W-1:0];
                REG_SPD_KP:  spd_kp_reg  <= pwdata[GAIN_W-1:0];
                REG_SPD_KI:  spd_ki_reg  <= pwdata[GAIN_W-1:0];
                REG_SPD_KD:  spd_kd_reg  <= pwdata[GAIN_W-1:0];
                REG_OUT_MAX: out_max_reg <= pwdata[OUTMAX_W-1:0];
                default:     ;
            endcase
        end
    end

    // datapath selection for the loop now in work
    always_comb
    begin
        cur_e    = loop_reg ? spd_err_reg : pos_err_reg;
        cur_prev = loop_reg ? prev_spd_err_reg : prev_pos_err_reg;
        cur_sum  = loop_reg ? spd_sum_reg : pos_sum_reg;
        e_new    = loop_reg ? (E_W'(setp_reg) - E_W'(sfb_reg))
                            : (E_W'(tgt_reg) - E_W'(fb_reg));

        sum_wide = (ACC_WIDTH+1)'(cur_sum) + (ACC_WIDTH+1)'(cur_e);
        if (sum_wide[ACC_WIDTH] != sum_wide[ACC_WIDTH-1])
            sum_sat = sum_wide[ACC_WIDTH] ? SUM_MIN : SUM_MAX;
        else
            sum_sat = sum_wide[ACC_WIDTH-1:0];

        // next operand goes into the multiplier while the current term is summed
        ld_term = (state_reg == S_ACC) ? term_t'(term_reg + 2'd1) : TERM_P;
        case (ld_term)
            TERM_P:  operand = OP_W'(cur_e);
            TERM_D:  operand = OP_W'(de_reg);
            TERM_I:  operand = OP_W'(cur_sum);
            default: operand = '0;
        endcase

        case (term_reg)
            TERM_P:  gain = loop_reg ? spd_kp_reg : pos_kp_reg;
            TERM_D:  gain = loop_reg ? spd_kd_reg : pos_kd_reg;
            TERM_I:  gain = loop_reg ? spd_ki_reg : pos_ki_reg;
            default: gain = '0;
        endcase

        // arithmetic shift floors toward minus infinity
        scaled = total >>> GAIN_FRAC;
        if (scaled > SETP_MAX)
            setp_cl = SETP_MAX;
        else if (scaled < SETP_MIN)
            setp_cl = SETP_MIN;
        else
            setp_cl = scaled;

        lim   = (out_max_reg < CAP) ? out_max_reg : CAP;
        lim_s = $signed(TOT_W'(lim));
        if (scaled > lim_s)
            drive_cl = lim_s;
        else if (scaled < -lim_s)
            drive_cl = -lim_s;
        else
            drive_cl = scaled;
    end

    assign chunk_last = (chunk_reg == CIW'(NCHUNK - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        ctrl       = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = func ? S_DONE : S_ERR;
            end
            S_ERR:
            begin
                state_next = S_UPD;
            end
            S_UPD:
            begin
                ctrl.load      = 1'b1;
                ctrl.clr_total = 1'b1;
                state_next     = S_MUL;
            end
            S_MUL:
            begin
                ctrl.mul_en    = 1'b1;
                ctrl.mul_first = (chunk_reg == '0);
                if (chunk_last)
                    state_next = S_ACC;
            end
            S_ACC:
            begin
                ctrl.acc_en = 1'b1;
                if (term_reg == TERM_I)
                    state_next = S_SCALE;
                else
                begin
                    ctrl.load  = 1'b1;
                    state_next = S_MUL;
                end
            end
            S_SCALE:
            begin
                state_next = loop_reg ? S_DONE : S_ERR;
            end
            S_DONE:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // loop state and sequencing counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_err_reg      <= '0;
            prev_pos_err_reg <= '0;
            pos_sum_reg      <= '0;
            spd_err_reg      <= '0;
            prev_spd_err_reg <= '0;
            spd_sum_reg      <= '0;
            loop_reg         <= 1'b0;
            term_reg         <= TERM_P;
            chunk_reg        <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    loop_reg <= 1'b0;
                    if (in_valid && func)
                    begin
                        pos_err_reg      <= '0;
                        prev_pos_err_reg <= '0;
                        pos_sum_reg      <= '0;
                    end
                end
                S_ERR:
                begin
                    if (loop_reg)
                    begin
                        prev_spd_err_reg <= spd_err_reg;
                        spd_err_reg      <= e_new;
                    end
                    else
                    begin
                        prev_pos_err_reg <= pos_err_reg;
                        pos_err_reg      <= e_new;
                    end
                end
                S_UPD:
                begin
                    if (loop_reg)
                        spd_sum_reg <= sum_sat;
                    else
                        pos_sum_reg <= sum_sat;
                    term_reg  <= TERM_P;
                    chunk_reg <= '0;
                end
                S_MUL:
                begin
                    chunk_reg <= chunk_last ? '0 : chunk_reg + 1'b1;
                end
                S_ACC:
                begin
                    if (term_reg != TERM_I)
                        term_reg <= term_t'(term_reg + 2'd1);
                end
                S_SCALE:
                begin
                    loop_reg <= 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    // working payload
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
        begin
            tgt_reg <= position_target;
            fb_reg  <= position_feedback;
            sfb_reg <= speed_feedback;
            if (func)
            begin
                setp_reg      <= '0;
                res_drive_reg <= '0;
            end
        end
        if (state_reg == S_UPD)
            de_reg <= DE_W'(cur_e) - DE_W'(cur_prev);
        if (state_reg == S_SCALE)
        begin
            if (loop_reg)
                res_drive_reg <= drive_cl[DRIVE_W-1:0];
            else
                setp_reg <= setp_cl[POS_WIDTH-1:0];
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (state_reg == S_DONE && out_free)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_DONE && out_free)
        begin
            drive_reg    <= res_drive_reg;
            setp_out_reg <= setp_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign drive          = drive_reg;
    assign speed_setpoint = setp_out_reg;

    cpsp_mac #(
        .OP_W   (OP_W),
        .NCHUNK (NCHUNK),
        .CIW    (CIW)
    ) u_mac (
        .clk       (clk),
        .ctrl      (ctrl),
        .chunk_sel (chunk_reg),
        .operand   (operand),
        .gain      (gain),
        .total     (total)
    );

    `CPSP_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready,
        "block ready again right after taking a transaction")
    `CPSP_ASSERT_NOW(a_drive_in_range, out_valid,
        ((DRIVE_W+1)'(drive) <= DRV_HI) && ((DRIVE_W+1)'(drive) >= DRV_LO),
        "drive outside the fixed cap")
    `CPSP_ASSERT_NOW(a_result_from_done, $rose(out_valid), $past(state_reg == S_DONE),
        "result raised outside the final state")

endmodule
